// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

    // Comparison results for one polygon edge against the query point.
    typedef struct packed {
        logic in_box;    // query lies within the edge's bounding box
        logic straddle;  // edge ends lie on opposite sides of the ray (half-open)
        logic upward;    // edge end is strictly above edge start
    } pip_edge_flags_t;

    // Number of edges examined per vertex: the incoming edge and the closing edge.
    localparam int unsigned EDGE_COUNT = 2;
    localparam int unsigned EDGE_IN    = 0;
    localparam int unsigned EDGE_CLOSE = 1;

endpackage

// File: rtl/pip_in_if.sv
`timescale 1ns / 1ps

interface pip_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         first_vertex;
    logic                         last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        output ready
    );
endinterface

// File: rtl/pip_out_if.sv
`timescale 1ns / 1ps

interface pip_out_if;
    logic valid;
    logic ready;
    logic is_inside;
    logic on_boundary;

    modport source (
        output valid, is_inside, on_boundary,
        input  ready
    );

    modport sink (
        input  valid, is_inside, on_boundary,
        output ready
    );
endinterface

// File: rtl/point_in_polygon_ray_cast.sv
`timescale 1ns / 1ps

// Even-odd point-in-polygon test over a stream of vertices, one vertex per
// transaction, with exact integer cross products. The block accepts one vertex
// in every cycle while the output does not stall it. The result of a polygon
// passes through the operand register, the product register and then the
// result register. The query point is taken on the vertex that opens a polygon,
// and a vertex that arrives with no polygon open opens one. A point on an edge
// reports both is_inside and on_boundary. Backpressure on the output stalls only
// when the final stage holds a result that cannot move; vertices that produce no
// result keep flowing.
module point_in_polygon_ray_cast #(
    parameter int COORD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pip_in_if.sink    in_ch,
    pip_out_if.source out_ch
);
    import pip_pkg::*;

    localparam int PW = 2 * COORD_BITS + 2;

    // Polygon context kept at the input side.
    logic                         have_prev_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] query_x_reg;
    logic signed [COORD_BITS-1:0] query_y_reg;

    // Operand stage.
    logic                         s1_valid_reg;
    logic                         s1_first_reg;
    logic                         s1_last_reg;
    logic signed [COORD_BITS-1:0] s1_prev_x_reg;
    logic signed [COORD_BITS-1:0] s1_prev_y_reg;
    logic signed [COORD_BITS-1:0] s1_cur_x_reg;
    logic signed [COORD_BITS-1:0] s1_cur_y_reg;
    logic signed [COORD_BITS-1:0] s1_start_x_reg;
    logic signed [COORD_BITS-1:0] s1_start_y_reg;
    logic signed [COORD_BITS-1:0] s1_q_x_reg;
    logic signed [COORD_BITS-1:0] s1_q_y_reg;

    // Product stage control.
    logic                         s2_valid_reg;
    logic                         s2_first_reg;
    logic                         s2_last_reg;

    // Result register.
    logic                         out_valid_reg;
    logic                         is_inside_reg;
    logic                         on_boundary_reg;
    logic                         out_valid_next;

    logic                         in_accept;
    logic                         open_poly;
    logic signed [COORD_BITS-1:0] start_x_next;
    logic signed [COORD_BITS-1:0] start_y_next;
    logic signed [COORD_BITS-1:0] query_x_next;
    logic signed [COORD_BITS-1:0] query_y_next;
    logic                         s2_go;
    logic                         s2_ready;
    logic                         s1_ready;
    logic                         s2_load;

    logic signed [PW-1:0]         in_prod_a;
    logic signed [PW-1:0]         in_prod_b;
    logic signed [PW-1:0]         close_prod_a;
    logic signed [PW-1:0]         close_prod_b;
    pip_edge_flags_t              in_flags;
    pip_edge_flags_t              close_flags;
    logic                         res_inside;
    logic                         res_boundary;

    // Stage handshakes: a vertex without a result never waits on the output.
    always_comb
    begin
        s2_go    = s2_valid_reg && (!s2_last_reg || !out_valid_reg || out_ch.ready);
        s2_ready = !s2_valid_reg || s2_go;
        s2_load  = s1_valid_reg && s2_ready;
        s1_ready = !s1_valid_reg || s2_ready;
    end

    assign in_ch.ready = s1_ready;
    assign in_accept   = in_ch.valid && s1_ready;

    // A vertex opens a polygon when flagged or when none is open.
    always_comb
    begin
        open_poly    = in_ch.first_vertex || !have_prev_reg;
        start_x_next = open_poly ? in_ch.vertex_x : start_x_reg;
        start_y_next = open_poly ? in_ch.vertex_y : start_y_reg;
        query_x_next = open_poly ? in_ch.query_x  : query_x_reg;
        query_y_next = open_poly ? in_ch.query_y  : query_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                have_prev_reg <= !in_ch.last_vertex;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Polygon context and operand capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_x_reg     <= in_ch.vertex_x;
            prev_y_reg     <= in_ch.vertex_y;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            query_x_reg    <= query_x_next;
            query_y_reg    <= query_y_next;
            s1_first_reg   <= open_poly;
            s1_last_reg    <= in_ch.last_vertex;
            s1_prev_x_reg  <= prev_x_reg;
            s1_prev_y_reg  <= prev_y_reg;
            s1_cur_x_reg   <= in_ch.vertex_x;
            s1_cur_y_reg   <= in_ch.vertex_y;
            s1_start_x_reg <= start_x_next;
            s1_start_y_reg <= start_y_next;
            s1_q_x_reg     <= query_x_next;
            s1_q_y_reg     <= query_y_next;
        end
        if (s2_load)
        begin
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Incoming edge: previous vertex to current vertex.
    pip_edge_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_in (
        .clk    (clk),
        .en     (s2_load),
        .a_x    (s1_prev_x_reg),
        .a_y    (s1_prev_y_reg),
        .b_x    (s1_cur_x_reg),
        .b_y    (s1_cur_y_reg),
        .q_x    (s1_q_x_reg),
        .q_y    (s1_q_y_reg),
        .prod_a (in_prod_a),
        .prod_b (in_prod_b),
        .flags  (in_flags)
    );

    // Closing edge: current vertex back to the first vertex.
    pip_edge_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_close (
        .clk    (clk),
        .en     (s2_load),
        .a_x    (s1_cur_x_reg),
        .a_y    (s1_cur_y_reg),
        .b_x    (s1_start_x_reg),
        .b_y    (s1_start_y_reg),
        .q_x    (s1_q_x_reg),
        .q_y    (s1_q_y_reg),
        .prod_a (close_prod_a),
        .prod_b (close_prod_b),
        .flags  (close_flags)
    );

    pip_parity #(
        .COORD_BITS (COORD_BITS)
    ) u_parity (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (s2_go),
        .first        (s2_first_reg),
        .last         (s2_last_reg),
        .in_prod_a    (in_prod_a),
        .in_prod_b    (in_prod_b),
        .in_flags     (in_flags),
        .close_prod_a (close_prod_a),
        .close_prod_b (close_prod_b),
        .close_flags  (close_flags),
        .res_inside   (res_inside),
        .res_boundary (res_boundary)
    );

    // Result register loads on a closing vertex and drains on an output transaction.
    always_comb
    begin
        if (s2_go && s2_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_last_reg)
        begin
            is_inside_reg   <= res_inside;
            on_boundary_reg <= res_boundary;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.is_inside   = is_inside_reg;
    assign out_ch.on_boundary = on_boundary_reg;

    // A boundary point always reports inside.
    a_boundary_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (!out_ch.on_boundary || out_ch.is_inside))
        else $error("on_boundary without is_inside");

    // A closing vertex leaves no polygon open.
    a_close_poly: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.last_vertex) |=> !have_prev_reg)
        else $error("polygon still open after last vertex");

    // A product-stage item that cannot move stays in place.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_go) |=> (s2_valid_reg && $stable(s2_last_reg)))
        else $error("stalled product stage item lost");
endmodule

// File: rtl/pip_edge_mul.sv
`timescale 1ns / 1ps

module pip_edge_mul #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [COORD_BITS-1:0]     a_x,
    input  logic signed [COORD_BITS-1:0]     a_y,
    input  logic signed [COORD_BITS-1:0]     b_x,
    input  logic signed [COORD_BITS-1:0]     b_y,
    input  logic signed [COORD_BITS-1:0]     q_x,
    input  logic signed [COORD_BITS-1:0]     q_y,
    output logic signed [2*COORD_BITS+1:0]   prod_a,
    output logic signed [2*COORD_BITS+1:0]   prod_b,
    output pip_pkg::pip_edge_flags_t         flags
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [DW-1:0]   edge_dx;
    logic signed [DW-1:0]   edge_dy;
    logic signed [DW-1:0]   q_dx;
    logic signed [DW-1:0]   q_dy;
    logic signed [PW-1:0]   prod_a_next;
    logic signed [PW-1:0]   prod_b_next;
    pip_edge_flags_t        flags_next;
    logic signed [PW-1:0]   prod_a_reg;
    logic signed [PW-1:0]   prod_b_reg;
    pip_edge_flags_t        flags_reg;

    // Differences are one bit wider than the coordinates, so they never overflow.
    always_comb
    begin
        edge_dx = DW'(b_x) - DW'(a_x);
        edge_dy = DW'(b_y) - DW'(a_y);
        q_dx    = DW'(q_x) - DW'(a_x);
        q_dy    = DW'(q_y) - DW'(a_y);
    end

    // The two partial products of the cross product (b - a) x (q - a).
    always_comb
    begin
        prod_a_next = PW'(edge_dx * q_dy);
        prod_b_next = PW'(edge_dy * q_dx);
    end

    // Bounding box and ray straddle tests on the raw coordinates.
    always_comb
    begin
        flags_next.in_box   = (((q_x >= a_x) && (q_x <= b_x)) || ((q_x >= b_x) && (q_x <= a_x)))
                           && (((q_y >= a_y) && (q_y <= b_y)) || ((q_y >= b_y) && (q_y <= a_y)));
        flags_next.straddle = (a_y >= q_y) != (b_y >= q_y);
        flags_next.upward   = b_y > a_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            flags_reg  <= flags_next;
        end
    end

    assign prod_a = prod_a_reg;
    assign prod_b = prod_b_reg;
    assign flags  = flags_reg;
endmodule

// File: rtl/pip_parity.sv
`timescale 1ns / 1ps

module pip_parity #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic                             first,
    input  logic                             last,
    input  logic signed [2*COORD_BITS+1:0]   in_prod_a,
    input  logic signed [2*COORD_BITS+1:0]   in_prod_b,
    input  pip_pkg::pip_edge_flags_t         in_flags,
    input  logic signed [2*COORD_BITS+1:0]   close_prod_a,
    input  logic signed [2*COORD_BITS+1:0]   close_prod_b,
    input  pip_pkg::pip_edge_flags_t         close_flags,
    output logic                             res_inside,
    output logic                             res_boundary
);
    import pip_pkg::*;

    localparam int CW = 2 * COORD_BITS + 3;

    logic signed [CW-1:0]       cross_val [EDGE_COUNT];
    pip_edge_flags_t            edge_flags [EDGE_COUNT];
    logic [EDGE_COUNT-1:0]      edge_use;
    logic [EDGE_COUNT-1:0]      edge_on;
    logic [EDGE_COUNT-1:0]      edge_flip;
    logic                       cross_parity_reg;
    logic                       edge_hit_reg;
    logic                       cross_parity_next;
    logic                       edge_hit_next;
    logic                       base_parity;
    logic                       base_hit;

    // The incoming edge exists unless this vertex opens a polygon; the closing
    // edge is tested only on the last vertex.
    always_comb
    begin
        cross_val[EDGE_IN]     = CW'(in_prod_a) - CW'(in_prod_b);
        cross_val[EDGE_CLOSE]  = CW'(close_prod_a) - CW'(close_prod_b);
        edge_flags[EDGE_IN]    = in_flags;
        edge_flags[EDGE_CLOSE] = close_flags;
        edge_use[EDGE_IN]      = !first;
        edge_use[EDGE_CLOSE]   = last;
    end

    // Per edge: on-edge when collinear and inside the box; a crossing when the
    // query lies strictly left of the edge oriented upward.
    always_comb
    begin
        for (int i = 0; i < EDGE_COUNT; i++)
        begin
            edge_on[i]   = edge_use[i] && (cross_val[i] == '0) && edge_flags[i].in_box;
            edge_flip[i] = edge_use[i] && edge_flags[i].straddle
                        && (edge_flags[i].upward ? (!cross_val[i][CW-1] && (cross_val[i] != '0))
                                                 : cross_val[i][CW-1]);
        end
    end

    // A new polygon starts from cleared parity and edge flag.
    always_comb
    begin
        base_parity       = first ? 1'b0 : cross_parity_reg;
        base_hit          = first ? 1'b0 : edge_hit_reg;
        cross_parity_next = base_parity ^ (^edge_flip);
        edge_hit_next     = base_hit | (|edge_on);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_parity_reg <= 1'b0;
            edge_hit_reg     <= 1'b0;
        end
        else if (go)
        begin
            cross_parity_reg <= cross_parity_next;
            edge_hit_reg     <= edge_hit_next;
        end
    end

    assign res_inside   = cross_parity_next | edge_hit_next;
    assign res_boundary = edge_hit_next;
endmodule

// File: tb/sv/pip_ray_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the point-in-polygon block. It keeps its own copy of
// the polygon state and predicts the verdict of every closed polygon. It then
// compares each result transaction with the oldest verdict still owed.
module pip_ray_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    pip_in_if    in_mon,
    pip_out_if   out_mon,
    output int   fail_count,
    output int   verdicts_owed,
    output int   verdicts_seen,
    output int   boundary_seen
);

    typedef struct {
        bit in_poly;
        bit boundary;
    } verdict_t;

    verdict_t verdict_q[$];

    // Predicted polygon state.
    logic signed [COORD_BITS-1:0] anchor_x, anchor_y;
    logic signed [COORD_BITS-1:0] trail_x, trail_y;
    logic signed [COORD_BITS-1:0] probe_x, probe_y;
    bit                           parity_odd;
    bit                           touched;
    bit                           poly_open;
    int                           errors;
    int                           seen;
    int                           seen_boundary;

    // Test one edge a->b against the held query point with exact arithmetic.
    function automatic void walk_edge(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        longint qx;
        longint qy;
        longint cr;
        longint up;
        qx = probe_x;
        qy = probe_y;
        cr = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
        if (cr == 0 &&
            qx >= ((ax < bx) ? ax : bx) && qx <= ((ax > bx) ? ax : bx) &&
            qy >= ((ay < by) ? ay : by) && qy <= ((ay > by) ? ay : by))
            touched = 1'b1;
        // Half-open rule: only edges that straddle the ray can cross it.
        if ((ay >= qy) != (by >= qy))
        begin
            up = (by > ay) ? cr : -cr;
            if (up > 0)
                parity_odd = ~parity_odd;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x      = '0;
            anchor_y      = '0;
            trail_x       = '0;
            trail_y       = '0;
            probe_x       = '0;
            probe_y       = '0;
            parity_odd    = 1'b0;
            touched       = 1'b0;
            poly_open     = 1'b0;
            errors        = 0;
            seen          = 0;
            seen_boundary = 0;
            verdict_q.delete();
            fail_count    <= 0;
            verdicts_owed <= 0;
            verdicts_seen <= 0;
            boundary_seen <= 0;
        end
        else
        begin
            // Update the prediction on every accepted vertex transaction.
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.first_vertex || !poly_open)
                begin
                    probe_x    = in_mon.query_x;
                    probe_y    = in_mon.query_y;
                    anchor_x   = in_mon.vertex_x;
                    anchor_y   = in_mon.vertex_y;
                    parity_odd = 1'b0;
                    touched    = 1'b0;
                end
                else
                begin
                    walk_edge(trail_x, trail_y, in_mon.vertex_x, in_mon.vertex_y);
                end
                trail_x   = in_mon.vertex_x;
                trail_y   = in_mon.vertex_y;
                poly_open = 1'b1;
                if (in_mon.last_vertex)
                begin
                    walk_edge(in_mon.vertex_x, in_mon.vertex_y, anchor_x, anchor_y);
                    verdict_q.push_back('{in_poly: parity_odd | touched, boundary: touched});
                    poly_open = 1'b0;
                end
            end

            // Compare every accepted result transaction with the oldest verdict.
            if (out_mon.valid && out_mon.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transaction with no verdict owed: is_inside %0b on_boundary %0b",
                           out_mon.is_inside, out_mon.on_boundary);
                    errors++;
                end
                else
                begin
                    verdict_t owed;
                    owed = verdict_q.pop_front();
                    seen++;
                    if (owed.boundary)
                        seen_boundary++;
                    if (out_mon.is_inside !== owed.in_poly)
                    begin
                        $error("is_inside: expected %0b, actual %0b",
                               owed.in_poly, out_mon.is_inside);
                        errors++;
                    end
                    if (out_mon.on_boundary !== owed.boundary)
                    begin
                        $error("on_boundary: expected %0b, actual %0b",
                               owed.boundary, out_mon.on_boundary);
                        errors++;
                    end
                end
            end

            fail_count    <= errors;
            verdicts_owed <= verdict_q.size();
            verdicts_seen <= seen;
            boundary_seen <= seen_boundary;
        end
    end

endmodule

// File: tb/sv/tb_point_in_polygon_ray_cast.sv
`timescale 1ns / 1ps

module tb_point_in_polygon_ray_cast;

    localparam int COORD_BITS  = 16;
    localparam int VERTEX_GOAL = 550;
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;

    pip_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
    pip_out_if                           out_ch ();

    int fail_count;
    int verdicts_owed;
    int verdicts_seen;
    int boundary_seen;

    int cycles;
    int burst_left;
    int vertices_sent;
    int stall_left = 0;
    int ready_mode = 0;

    point_in_polygon_ray_cast #(.COORD_BITS(COORD_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pip_ray_checker #(.COORD_BITS(COORD_BITS)) verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed),
        .verdicts_seen (verdicts_seen),
        .boundary_seen (boundary_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Guard against a hung handshake.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side: ready is always high, random, or held low in random stall bursts, by a mode drawn at random.
    always @(posedge clk)
    begin
        bit take;
        if (cycles % 64 == 0)
            ready_mode = $urandom_range(0, 2);
        case (ready_mode)
            0: take = 1'b1;
            1: take = 1'($urandom_range(0, 1));
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    take = 1'b0;
                end
                else
                begin
                    take = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 20);
                end
            end
        endcase
        out_ch.ready <= take;
    end

    // Offer one vertex transaction, in bursts with random gaps, and wait until taken.
    task automatic send_vertex(input logic signed [15:0] qx, input logic signed [15:0] qy,
                               input logic signed [15:0] vx, input logic signed [15:0] vy,
                               input bit fv, input bit lv);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid        <= 1'b1;
        in_ch.query_x      <= qx;
        in_ch.query_y      <= qy;
        in_ch.vertex_x     <= vx;
        in_ch.vertex_y     <= vy;
        in_ch.first_vertex <= fv;
        in_ch.last_vertex  <= lv;
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        vertices_sent++;
    endtask

    // Hold the input idle until every owed verdict has been delivered.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord(input int span);
        if (span == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    // One polygon with random content; a few are broken sequences with random flags.
    task automatic random_polygon();
        int                  count;
        int                  span;
        int                  qmode;
        int                  k;
        bit                  noisy;
        bit                  fv;
        bit                  lv;
        logic signed [15:0]  px[8];
        logic signed [15:0]  py[8];
        logic signed [15:0]  qx;
        logic signed [15:0]  qy;
        logic signed [16:0]  sum;
        count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        span  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < count; i++)
        begin
            px[i] = pick_coord(span);
            py[i] = pick_coord(span);
        end
        // Put the query on a vertex, near an edge midpoint, or anywhere.
        qmode = $urandom_range(0, 3);
        k = $urandom_range(0, count - 1);
        case (qmode)
            0:
            begin
                qx = px[k];
                qy = py[k];
            end
            1:
            begin
                sum = px[k] + px[(k + 1) % count];
                qx  = 16'(sum >>> 1);
                sum = py[k] + py[(k + 1) % count];
                qy  = 16'(sum >>> 1);
            end
            2:
            begin
                qx = pick_coord(span);
                qy = pick_coord(span);
            end
            default:
            begin
                qx = 16'($urandom());
                qy = 16'($urandom());
            end
        endcase
        for (int i = 0; i < count; i++)
        begin
            fv = (i == 0);
            lv = (i == count - 1);
            if (noisy)
            begin
                fv = ($urandom_range(0, 3) == 0);
                lv = ($urandom_range(0, 3) == 0);
            end
            if (i == 0)
                send_vertex(qx, qy, px[i], py[i], fv, lv);
            else
                send_vertex(16'($urandom()), 16'($urandom()), px[i], py[i], fv, lv);
        end
    endtask

    initial
    begin
        bit midway_done;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.query_x      <= '0;
        in_ch.query_y      <= '0;
        in_ch.vertex_x     <= '0;
        in_ch.vertex_y     <= '0;
        in_ch.first_vertex <= 1'b0;
        in_ch.last_vertex  <= 1'b0;
        burst_left    = 0;
        vertices_sent = 0;
        midway_done   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A square opened without first_vertex, right after reset; query inside.
        send_vertex(16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd9, 16'sd9, -16'sd5, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd9, 16'sd9, -16'sd5, -16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd9, 16'sd9, 16'sd5, -16'sd5, 1'b0, 1'b1);
        // Single-vertex polygons: query on the vertex, then just beside it.
        send_vertex(16'sd7, -16'sd3, 16'sd7, -16'sd3, 1'b1, 1'b1);
        send_vertex(16'sd7, -16'sd3, 16'sd8, -16'sd3, 1'b1, 1'b1);
        // Full-range square around the origin.
        send_vertex(16'sd0, 16'sd0, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 1'b0, 1'b1);
        // Extreme triangle with the query on a corner.
        send_vertex(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0, 1'b1);
        // Repeated vertex and a horizontal edge level with the query, query outside.
        send_vertex(-16'sd10, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd10, 16'sd0, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b0, 1'b1);
        // Query on the line of an edge, just past its end, far corner of the field.
        send_vertex(16'sd32767, -16'sd32768, 16'sd32767, 16'sd0, 1'b1, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd32767, -16'sd32767, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd0, -16'sd20000, 1'b0, 1'b1);
        // A polygon restarted midway by a second first_vertex, then closed.
        send_vertex(16'sd1, 16'sd1, 16'sd50, 16'sd50, 1'b1, 1'b0);
        send_vertex(16'sd2, 16'sd2, -16'sd4, -16'sd4, 1'b1, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd8, -16'sd4, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd2, 16'sd9, 1'b0, 1'b1);
        drain_results();

        // Random polygons, with one full drain halfway through.
        while (vertices_sent < VERTEX_GOAL)
        begin
            random_polygon();
            if (!midway_done && vertices_sent > VERTEX_GOAL / 2)
            begin
                drain_results();
                midway_done = 1'b1;
            end
        end
        // Close any polygon left open by a broken sequence.
        send_vertex(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                    1'b0, 1'b1);
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d vertex transactions in %0d cycles.", vertices_sent, cycles);
        $display("Checked %0d polygon verdicts, %0d with the point on an edge.",
                 verdicts_seen, boundary_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
